// ----- rtl/core/tse_pkg.sv -----
// Shared types, widths and codes for the topological sort engine.
package tse_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_EDGES_DEF    = 64;

    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int DEG_W    = 7;
    localparam int VCOUNT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_VERTEX = 2'd0,
        FUNC_LOAD_EDGE   = 2'd1,
        FUNC_RUN         = 2'd2,
        FUNC_CLEAR       = 2'd3
    } func_e_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] order_value;
        logic                      is_status;
        logic                      acyclic;
        logic                      last;
    } tse_result_t;

endpackage

// ----- rtl/core/tse_ram.sv -----
// Single-port-write, single-port-read memory with registered read data.
module tse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tse_seq.sv -----
// Sequencer for graph loading and topological sort over the vertex, edge and stack memories.
module tse_seq
    import tse_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [VCOUNT_W-1:0]       vertex_count,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FUNC_W-1:0]         func,
    input  logic [IDX_W-1:0]          vertex_index,
    input  logic signed [VALUE_W-1:0] vertex_value,
    input  logic [DEG_W-1:0]          in_degree,
    input  logic [IDX_W-1:0]          edge_from,
    input  logic [IDX_W-1:0]          edge_to,
    input  logic                      res_free,
    output logic                      res_push,
    output tse_result_t               res
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int TW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_VREAD,
        ST_EMIT,
        ST_WALK_RD,
        ST_WALK_DEG,
        ST_WALK_UPD,
        ST_STATUS
    } state_t;

    state_t                  state_reg, state_next;
    logic [TW-1:0]           n_reg, n_next;
    logic [TW-1:0]           i_reg, i_next;
    logic [TW-1:0]           top_reg, top_next;
    logic [TW-1:0]           emitted_reg, emitted_next;
    logic [CW-1:0]           edges_used_reg, edges_used_next;
    logic [MAX_VERTICES-1:0] full_reg, full_next;
    logic [EW-1:0]           eu_reg, eu_next;
    logic                    link_reg, link_next;
    logic                    v_full_reg, v_full_next;
    logic [EW-1:0]           e_reg, e_next;
    logic [EW-1:0]           tail_reg, tail_next;
    logic [VW-1:0]           d_reg, d_next;

    logic                    val_we, val_re;
    logic [VW-1:0]           val_waddr, val_raddr;
    logic [VALUE_W-1:0]      val_wdata, val_rd;
    logic                    deg_we, deg_re;
    logic [VW-1:0]           deg_waddr, deg_raddr;
    logic [DEG_W-1:0]        deg_wdata, deg_rd;
    logic                    head_we, head_re;
    logic [VW-1:0]           head_waddr, head_raddr;
    logic [EW-1:0]           head_wdata, head_rd;
    logic                    tl_we, tl_re;
    logic [VW-1:0]           tl_waddr, tl_raddr;
    logic [EW-1:0]           tl_wdata, tl_rd;
    logic                    dst_we, dst_re;
    logic [EW-1:0]           dst_waddr, dst_raddr;
    logic [VW-1:0]           dst_wdata, dst_rd;
    logic                    nxt_we, nxt_re;
    logic [EW-1:0]           nxt_waddr, nxt_raddr;
    logic [EW-1:0]           nxt_wdata, nxt_rd;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr;
    logic [VW-1:0]           stk_wdata, stk_rd;

    logic                    vi_ok, ep_ok, room, stk_room;
    logic [VW-1:0]           vi, ef, et;
    logic [EW-1:0]           eu;
    logic [TW-1:0]           n_calc, top_dec;

    assign vi       = VW'(vertex_index);
    assign ef       = VW'(edge_from);
    assign et       = VW'(edge_to);
    assign eu       = edges_used_reg[EW-1:0];
    assign vi_ok    = 32'(vertex_index) < MAX_VERTICES;
    assign ep_ok    = (32'(edge_from) < MAX_VERTICES) && (32'(edge_to) < MAX_VERTICES);
    assign room     = 32'(edges_used_reg) < MAX_EDGES;
    assign stk_room = 32'(top_reg) < MAX_VERTICES;
    assign n_calc   = (32'(vertex_count) < MAX_VERTICES) ? TW'(vertex_count)
                                                         : TW'(MAX_VERTICES);
    assign top_dec  = top_reg - TW'(1);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        top_next        = top_reg;
        emitted_next    = emitted_reg;
        edges_used_next = edges_used_reg;
        full_next       = full_reg;
        eu_next         = eu_reg;
        link_next       = link_reg;
        v_full_next     = v_full_reg;
        e_next          = e_reg;
        tail_next       = tail_reg;
        d_next          = d_reg;
        val_we = 1'b0; val_re = 1'b0; val_waddr = '0; val_raddr = '0; val_wdata = '0;
        deg_we = 1'b0; deg_re = 1'b0; deg_waddr = '0; deg_raddr = '0; deg_wdata = '0;
        head_we = 1'b0; head_re = 1'b0; head_waddr = '0; head_raddr = '0; head_wdata = '0;
        tl_we = 1'b0; tl_re = 1'b0; tl_waddr = '0; tl_raddr = '0; tl_wdata = '0;
        dst_we = 1'b0; dst_re = 1'b0; dst_waddr = '0; dst_raddr = '0; dst_wdata = '0;
        nxt_we = 1'b0; nxt_re = 1'b0; nxt_waddr = '0; nxt_raddr = '0; nxt_wdata = '0;
        stk_we = 1'b0; stk_re = 1'b0; stk_waddr = '0; stk_raddr = '0; stk_wdata = '0;
        res_push = 1'b0;
        res      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (func_e_t'(func))
                        FUNC_LOAD_VERTEX: begin
                            if (vi_ok) begin
                                val_we    = 1'b1;
                                val_waddr = vi;
                                val_wdata = vertex_value;
                                deg_we    = 1'b1;
                                deg_waddr = vi;
                                deg_wdata = in_degree;
                            end
                        end
                        FUNC_LOAD_EDGE: begin
                            if (ep_ok && room) begin
                                dst_we     = 1'b1;
                                dst_waddr  = eu;
                                dst_wdata  = et;
                                tl_re      = 1'b1;
                                tl_raddr   = ef;
                                tl_we      = 1'b1;
                                tl_waddr   = ef;
                                tl_wdata   = eu;
                                head_we    = !full_reg[ef];
                                head_waddr = ef;
                                head_wdata = eu;
                                full_next[ef]   = 1'b1;
                                edges_used_next = edges_used_reg + CW'(1);
                                eu_next    = eu;
                                link_next  = full_reg[ef];
                                state_next = ST_LINK;
                            end
                        end
                        FUNC_RUN: begin
                            n_next       = n_calc;
                            i_next       = '0;
                            top_next     = '0;
                            emitted_next = '0;
                            state_next   = ST_SCAN_RD;
                        end
                        FUNC_CLEAR: begin
                            full_next       = '0;
                            edges_used_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LINK: begin
                nxt_we     = link_reg;
                nxt_waddr  = tl_rd;
                nxt_wdata  = eu_reg;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (i_reg == n_reg) begin
                    state_next = ST_POP;
                end else begin
                    deg_re     = 1'b1;
                    deg_raddr  = i_reg[VW-1:0];
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (deg_rd == '0 && stk_room) begin
                    stk_we    = 1'b1;
                    stk_waddr = top_reg[VW-1:0];
                    stk_wdata = i_reg[VW-1:0];
                    top_next  = top_reg + TW'(1);
                end
                i_next     = i_reg + TW'(1);
                state_next = ST_SCAN_RD;
            end
            ST_POP: begin
                if (top_reg == '0) begin
                    state_next = ST_STATUS;
                end else begin
                    stk_re     = 1'b1;
                    stk_raddr  = top_dec[VW-1:0];
                    top_next   = top_dec;
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD: begin
                val_re      = 1'b1;
                val_raddr   = stk_rd;
                head_re     = 1'b1;
                head_raddr  = stk_rd;
                tl_re       = 1'b1;
                tl_raddr    = stk_rd;
                v_full_next = full_reg[stk_rd];
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (res_free) begin
                    res_push          = 1'b1;
                    res.order_value   = val_rd;
                    emitted_next      = emitted_reg + TW'(1);
                    if (v_full_reg) begin
                        e_next     = head_rd;
                        tail_next  = tl_rd;
                        state_next = ST_WALK_RD;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_WALK_RD: begin
                dst_re     = 1'b1;
                dst_raddr  = e_reg;
                nxt_re     = 1'b1;
                nxt_raddr  = e_reg;
                state_next = ST_WALK_DEG;
            end
            ST_WALK_DEG: begin
                d_next = dst_rd;
                if (TW'(dst_rd) < n_reg) begin
                    deg_re     = 1'b1;
                    deg_raddr  = dst_rd;
                    state_next = ST_WALK_UPD;
                end else if (e_reg == tail_reg) begin
                    state_next = ST_POP;
                end else begin
                    e_next     = nxt_rd;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_UPD: begin
                if (deg_rd != '0) begin
                    deg_we    = 1'b1;
                    deg_waddr = d_reg;
                    deg_wdata = deg_rd - DEG_W'(1);
                    if (deg_rd == DEG_W'(1) && stk_room) begin
                        stk_we    = 1'b1;
                        stk_waddr = top_reg[VW-1:0];
                        stk_wdata = d_reg;
                        top_next  = top_reg + TW'(1);
                    end
                end
                if (e_reg == tail_reg) begin
                    state_next = ST_POP;
                end else begin
                    e_next     = nxt_rd;
                    state_next = ST_WALK_RD;
                end
            end
            ST_STATUS: begin
                if (res_free) begin
                    res_push      = 1'b1;
                    res.is_status = 1'b1;
                    res.acyclic   = (emitted_reg >= n_reg);
                    res.last      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edges_used_reg <= '0;
            full_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            edges_used_reg <= edges_used_next;
            full_reg       <= full_next;
        end
        n_reg       <= n_next;
        i_reg       <= i_next;
        top_reg     <= top_next;
        emitted_reg <= emitted_next;
        eu_reg      <= eu_next;
        link_reg    <= link_next;
        v_full_reg  <= v_full_next;
        e_reg       <= e_next;
        tail_reg    <= tail_next;
        d_reg       <= d_next;
    end

    tse_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VERTICES)) u_val_ram (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .re(val_re), .raddr(val_raddr), .rdata(val_rd)
    );

    tse_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .aclk(aclk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .re(deg_re), .raddr(deg_raddr), .rdata(deg_rd)
    );

    tse_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rd)
    );

    tse_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail_ram (
        .aclk(aclk), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
        .re(tl_re), .raddr(tl_raddr), .rdata(tl_rd)
    );

    tse_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_dst_ram (
        .aclk(aclk), .we(dst_we), .waddr(dst_waddr), .wdata(dst_wdata),
        .re(dst_re), .raddr(dst_raddr), .rdata(dst_rd)
    );

    tse_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_nxt_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rd)
    );

    tse_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
    );

endmodule

// ----- rtl/core/topological_sort_engine_unit.sv -----
// Top level of the topological sort engine: config register, sequencer, result register.
// Load edge passes ST_LINK; load vertex and clear stay idle; s_ready is low while busy.
// A run scans each vertex, then pops the stack, emits each vertex and walks its edges,
// one access at a time through the single-port memories.
// Stalls on m_ready hold the sequencer; one result register decouples the output side.
// Synchronous active-low reset: idle, edge lists empty, vertex_count 0, no clearing pass.
module topological_sort_engine_unit
    import tse_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [VCOUNT_W-1:0]       cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FUNC_W-1:0]         s_func,
    input  logic [IDX_W-1:0]          s_vertex_index,
    input  logic signed [VALUE_W-1:0] s_vertex_value,
    input  logic [DEG_W-1:0]          s_in_degree,
    input  logic [IDX_W-1:0]          s_edge_from,
    input  logic [IDX_W-1:0]          s_edge_to,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [VALUE_W-1:0] m_order_value,
    output logic                      m_is_status,
    output logic                      m_acyclic,
    output logic                      m_last
);

    logic [VCOUNT_W-1:0] vertex_count_reg, vertex_count_next;
    logic                out_valid_reg, out_valid_next;
    tse_result_t         out_data_reg;
    logic                res_free, res_push;
    tse_result_t         res;

    assign res_free = !out_valid_reg || m_ready;

    always_comb begin
        vertex_count_next = cfg_wr_en ? cfg_wr_data : vertex_count_reg;
        if (res_push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            vertex_count_reg <= vertex_count_next;
            out_valid_reg    <= out_valid_next;
        end
        if (res_push) begin
            out_data_reg <= res;
        end
    end

    tse_seq #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .vertex_count(vertex_count_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .func        (s_func),
        .vertex_index(s_vertex_index),
        .vertex_value(s_vertex_value),
        .in_degree   (s_in_degree),
        .edge_from   (s_edge_from),
        .edge_to     (s_edge_to),
        .res_free    (res_free),
        .res_push    (res_push),
        .res         (res)
    );

    assign m_valid       = out_valid_reg;
    assign m_order_value = out_data_reg.order_value;
    assign m_is_status   = out_data_reg.is_status;
    assign m_acyclic     = out_data_reg.acyclic;
    assign m_last        = out_data_reg.last;

endmodule

// ----- rtl/core/tse_checker.sv -----
// Port-level checker for the topological sort engine and its bind.
module tse_checker
    import tse_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [FUNC_W-1:0]         s_func,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [VALUE_W-1:0] m_order_value,
    input logic                      m_is_status,
    input logic                      m_acyclic,
    input logic                      m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_order_value) &&
            $stable(m_is_status) && $stable(m_acyclic) && $stable(m_last))
        else $error("result changed while stalled");

    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == m_is_status))
        else $error("last and status flags disagree");

    a_vertex_acyclic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |-> !m_acyclic)
        else $error("acyclic set on a vertex result");

    a_status_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> (m_order_value == '0))
        else $error("status result carries a value");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == FUNC_RUN) |=> !s_ready)
        else $error("ready right after a run transaction");

endmodule

bind topological_sort_engine_unit tse_checker u_tse_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_func       (s_func),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_order_value(m_order_value),
    .m_is_status  (m_is_status),
    .m_acyclic    (m_acyclic),
    .m_last       (m_last)
);

// ----- tb/topological_sort_engine_unit_tb.sv -----
// Self-checking testbench for the topological sort engine: random graphs against a predicted order.
`timescale 1ns / 1ps

module topological_sort_engine_unit_tb;
    import tse_pkg::*;

    localparam int MAXV          = MAX_VERTICES_DEF;
    localparam int MAXE          = MAX_EDGES_DEF;
    localparam int ITEM_TARGET   = 420;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 300;

    typedef struct packed {
        bit                        is_cfg;
        logic [VCOUNT_W-1:0]       vcount;
        func_e_t                   func;
        logic [IDX_W-1:0]          vidx;
        logic signed [VALUE_W-1:0] value;
        logic [DEG_W-1:0]          deg;
        logic [IDX_W-1:0]          efrom;
        logic [IDX_W-1:0]          eto;
        int                        gap;
    } graph_op_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [VCOUNT_W-1:0]       cfg_wr_data    = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [FUNC_W-1:0]         s_func         = '0;
    logic [IDX_W-1:0]          s_vertex_index = '0;
    logic signed [VALUE_W-1:0] s_vertex_value = '0;
    logic [DEG_W-1:0]          s_in_degree    = '0;
    logic [IDX_W-1:0]          s_edge_from    = '0;
    logic [IDX_W-1:0]          s_edge_to      = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [VALUE_W-1:0] m_order_value;
    logic                      m_is_status;
    logic                      m_acyclic;
    logic                      m_last;

    // graph mirror
    logic signed [VALUE_W-1:0] vtx_value [MAXV];
    logic [DEG_W-1:0]          vtx_deg [MAXV];
    logic [IDX_W-1:0]          edge_src [MAXE];
    logic [IDX_W-1:0]          edge_dst [MAXE];
    int                        edges_held = 0;
    int                        vcount_now = 0;
    tse_result_t               due_results [$];
    tse_result_t               wanted;

    // stimulus build state
    graph_op_t                 ops_to_send [$];
    int                        gen_n = 0;
    bit [MAXV-1:0]             gen_loaded = '0;
    bit                        in_burst = 1'b0;
    int                        item_count = 0;

    // handshake bookkeeping
    graph_op_t                 head_op;
    logic                      nxt_valid;
    logic                      nxt_cfg_en;
    int                        gap_left = -1;
    int                        settle_cnt = 0;
    int                        ops_issued = 0;
    int                        ops_taken = 0;
    int                        results_taken = 0;
    int                        results_paced = 0;
    int                        stall_left = 0;
    bit                        out_burst = 1'b0;
    int                        mismatches = 0;

    topological_sort_engine_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_vertex_index (s_vertex_index),
        .s_vertex_value (s_vertex_value),
        .s_in_degree    (s_in_degree),
        .s_edge_from    (s_edge_from),
        .s_edge_to      (s_edge_to),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_order_value  (m_order_value),
        .m_is_status    (m_is_status),
        .m_acyclic      (m_acyclic),
        .m_last         (m_last)
    );

    always #10 aclk = ~aclk;

    task automatic sort_graph();
        int          n;
        int          v;
        int          d;
        int          e;
        int          emitted;
        int          depth;
        int          stack_buf [MAXV];
        tse_result_t r;
        n = (vcount_now > MAXV) ? MAXV : vcount_now;
        depth = 0;
        emitted = 0;
        for (v = 0; v < n; v++) begin
            if (vtx_deg[v] == 0) begin
                stack_buf[depth] = v;
                depth++;
            end
        end
        while (depth != 0) begin
            depth--;
            v = stack_buf[depth];
            r.order_value = vtx_value[v];
            r.is_status = 1'b0;
            r.acyclic = 1'b0;
            r.last = 1'b0;
            due_results.push_back(r);
            emitted++;
            // walk successors in load order
            for (e = 0; e < edges_held; e++) begin
                d = int'(edge_dst[e]);
                if (int'(edge_src[e]) == v && d < n && vtx_deg[d] != 0) begin
                    vtx_deg[d] = vtx_deg[d] - 1'b1;
                    if (vtx_deg[d] == 0) begin
                        stack_buf[depth] = d;
                        depth++;
                    end
                end
            end
        end
        r.order_value = '0;
        r.is_status = 1'b1;
        r.acyclic = (emitted >= n);
        r.last = 1'b1;
        due_results.push_back(r);
    endtask

    task automatic apply_graph_op(func_e_t f, logic [IDX_W-1:0] vi,
                                  logic signed [VALUE_W-1:0] val, logic [DEG_W-1:0] deg,
                                  logic [IDX_W-1:0] ef, logic [IDX_W-1:0] et);
        case (f)
            FUNC_LOAD_VERTEX: begin
                vtx_value[vi] = val;
                vtx_deg[vi] = deg;
            end
            FUNC_LOAD_EDGE: begin
                // drop once the store is full
                if (edges_held < MAXE) begin
                    edge_src[edges_held] = ef;
                    edge_dst[edges_held] = et;
                    edges_held++;
                end
            end
            FUNC_CLEAR: begin
                edges_held = 0;
            end
            default: begin
                sort_graph();
            end
        endcase
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic graph_op_t fresh_op(func_e_t f);
        graph_op_t op;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        op.is_cfg = 1'b0;
        op.vcount = '0;
        op.func = f;
        op.vidx = IDX_W'($urandom());
        op.value = pick_value();
        op.deg = DEG_W'($urandom_range(0, 64));
        op.efrom = IDX_W'($urandom());
        op.eto = IDX_W'($urandom());
        op.gap = in_burst ? 0 : $urandom_range(0, 6);
        return op;
    endfunction

    task automatic send_op(graph_op_t op);
        if (op.func == FUNC_LOAD_VERTEX) gen_loaded[op.vidx] = 1'b1;
        ops_to_send.push_back(op);
        item_count++;
    endtask

    task automatic send_vertex(int idx, logic signed [VALUE_W-1:0] val, int deg);
        graph_op_t op;
        op = fresh_op(FUNC_LOAD_VERTEX);
        op.vidx = IDX_W'(idx);
        op.value = val;
        op.deg = DEG_W'(deg);
        send_op(op);
    endtask

    task automatic send_edge(int from_v, int to_v);
        graph_op_t op;
        op = fresh_op(FUNC_LOAD_EDGE);
        op.efrom = IDX_W'(from_v);
        op.eto = IDX_W'(to_v);
        send_op(op);
    endtask

    task automatic send_cfg(int count);
        graph_op_t op;
        op = fresh_op(FUNC_RUN);
        op.is_cfg = 1'b1;
        op.vcount = VCOUNT_W'(count);
        ops_to_send.push_back(op);
        gen_n = (count > MAXV) ? MAXV : count;
    endtask

    task automatic send_run();
        int i;
        // load any in-use vertex that was never written
        for (i = 0; i < gen_n; i++) begin
            if (!gen_loaded[i]) send_vertex(i, pick_value(), $urandom_range(0, 3));
        end
        send_op(fresh_op(FUNC_RUN));
    endtask

    task automatic send_graph(bit broken);
        int perm [MAXV];
        int deg [MAXV];
        int src [40];
        int dst [40];
        int i;
        int j;
        int a;
        int b;
        int tmp;
        int n_edges;
        for (i = 0; i < MAXV; i++) begin
            perm[i] = i;
            deg[i] = 0;
        end
        for (i = gen_n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        if (!broken || $urandom_range(0, 1) == 0) send_op(fresh_op(FUNC_CLEAR));
        n_edges = (gen_n < 2) ? 0 : $urandom_range(0, 2 * gen_n);
        for (i = 0; i < n_edges; i++) begin
            a = $urandom_range(0, gen_n - 2);
            b = $urandom_range(a + 1, gen_n - 1);
            src[i] = perm[a];
            dst[i] = perm[b];
            deg[perm[b]]++;
        end
        if (gen_n > 0 && gen_n < MAXV && $urandom_range(0, 2) == 0) begin
            src[n_edges] = $urandom_range(0, gen_n - 1);
            dst[n_edges] = $urandom_range(gen_n, MAXV - 1);
            n_edges++;
        end
        if (broken && gen_n >= 2) begin
            src[n_edges] = perm[gen_n - 1];
            dst[n_edges] = perm[0];
            deg[perm[0]]++;
            n_edges++;
        end
        if (broken && gen_n >= 1 && $urandom_range(0, 1) == 0) begin
            deg[$urandom_range(0, gen_n - 1)]++;
        end
        for (i = 0; i < gen_n; i++) send_vertex(perm[i], pick_value(), deg[perm[i]]);
        for (i = 0; i < n_edges; i++) send_edge(src[i], dst[i]);
        send_run();
    endtask

    task automatic send_edge_flood();
        int i;
        send_op(fresh_op(FUNC_CLEAR));
        for (i = 0; i < MAXV; i++) send_vertex(i, pick_value(), $urandom_range(0, 8));
        for (i = 0; i < MAXE + 6; i++) begin
            send_edge($urandom_range(0, MAXV - 1), $urandom_range(0, MAXV - 1));
        end
        send_run();
    endtask

    function automatic int pick_count();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return MAXV;
            4: return 31;
            5: return $urandom_range(MAXV + 1, 30);
            default: return $urandom_range(3, 9);
        endcase
    endfunction

    // sender: one transaction at a time, config writes only when drained
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            nxt_cfg_en = 1'b0;
            if (s_valid && ops_taken != ops_issued) begin
                settle_cnt = 0;
            end else begin
                nxt_valid = 1'b0;
                if (due_results.size() != 0) settle_cnt = 0;
                else settle_cnt++;
                if (ops_to_send.size() != 0) begin
                    head_op = ops_to_send[0];
                    if (head_op.is_cfg) begin
                        if (settle_cnt >= SETTLE_CYCLES) begin
                            nxt_cfg_en = 1'b1;
                            cfg_wr_data <= head_op.vcount;
                            vcount_now = int'(head_op.vcount);
                            void'(ops_to_send.pop_front());
                            settle_cnt = 0;
                        end
                    end else begin
                        if (gap_left < 0) gap_left = head_op.gap;
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            s_func <= head_op.func;
                            s_vertex_index <= head_op.vidx;
                            s_vertex_value <= head_op.value;
                            s_in_degree <= head_op.deg;
                            s_edge_from <= head_op.efrom;
                            s_edge_to <= head_op.eto;
                            nxt_valid = 1'b1;
                            ops_issued++;
                            void'(ops_to_send.pop_front());
                            gap_left = -1;
                        end
                    end
                end
            end
            s_valid <= nxt_valid;
            cfg_wr_en <= nxt_cfg_en;
        end
    end

    // receiver: random stall after each result, with stall-free stretches
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (results_taken != results_paced) begin
                results_paced = results_taken;
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
                stall_left = out_burst ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            apply_graph_op(func_e_t'(s_func), s_vertex_index, s_vertex_value, s_in_degree,
                           s_edge_from, s_edge_to);
            ops_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (due_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: value %0d status %0b acyclic %0b last %0b",
                             m_order_value, m_is_status, m_acyclic, m_last);
                end
                mismatches++;
            end else begin
                wanted = due_results.pop_front();
                if (m_order_value !== wanted.order_value || m_is_status !== wanted.is_status ||
                    m_acyclic !== wanted.acyclic || m_last !== wanted.last) begin
                    if (mismatches < 10) begin
                        $display("result mismatch: expected value %0d status %0b acyclic %0b %s",
                                 wanted.order_value, wanted.is_status, wanted.acyclic,
                                 wanted.last ? "last" : "not last");
                        $display("                 actual   value %0d status %0b acyclic %0b %s",
                                 m_order_value, m_is_status, m_acyclic,
                                 m_last ? "last" : "not last");
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        // directed: empty graph, field extremes, stuck vertex, repeated run, clear
        send_cfg(0);
        send_run();
        send_cfg(4);
        send_vertex(0, 32'sh7FFF_FFFF, 0);
        send_vertex(1, 32'sh8000_0000, 1);
        send_vertex(2, '0, 2);
        send_vertex(3, -32'sd1, 64);
        send_vertex(15, 32'sh5555_5555, 63);
        send_edge(0, 1);
        send_edge(0, 2);
        send_edge(1, 2);
        send_edge(2, 0);
        send_edge(2, 15);
        send_edge(15, 15);
        send_run();
        send_run();
        send_op(fresh_op(FUNC_CLEAR));
        send_vertex(3, 32'sh0000_ABCD, 0);
        send_run();

        send_cfg(31);
        send_graph(1'b0);
        send_cfg(MAXV);
        send_edge_flood();
        while (item_count < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1: send_cfg(pick_count());
                2: begin
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 5))
                            0: send_op(fresh_op(FUNC_CLEAR));
                            1, 2: send_op(fresh_op(FUNC_LOAD_EDGE));
                            3: send_run();
                            default: send_op(fresh_op(FUNC_LOAD_VERTEX));
                        endcase
                    end
                end
                3: send_graph(1'b1);
                default: send_graph(1'b0);
            endcase
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (ops_to_send.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
